@@ hdl/rbpcd_pkg.sv @@
// Shared types and constants for the report bit packer with change detection.
// Holds the item and result payload structs, action codes, the controller state
// type and the command and status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package rbpcd_pkg;

	localparam int RBP_MAX_BYTES = 64;

	localparam logic [6:0] RBP_LEN_RESET = 7'd8;

	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_RESTART  = 3'd1;
	localparam logic [2:0] ACT_ADD_BYTE = 3'd2;
	localparam logic [2:0] ACT_ADD_BIT  = 3'd3;
	localparam logic [2:0] ACT_FILL     = 3'd4;
	localparam logic [2:0] ACT_FINISH   = 3'd5;
	localparam logic [2:0] ACT_READ     = 3'd6;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic       bit_value;
		logic [7:0] bit_count;
		logic [5:0] byte_index;
	} rbp_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       changed;
		logic [9:0] bit_position;
	} rbp_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_DONE
	} rbp_state_t;

	typedef struct packed {
		logic load;
		logic rd_issue;
		logic step;
		logic out_load;
	} rbp_cmd_t;

	typedef struct packed {
		logic more;
		logic out_full;
	} rbp_status_t;

endpackage

`default_nettype wire

@@ hdl/rbpcd_ctrl.sv @@
// Controller for the report bit packer: sequences accept, memory read,
// byte step and result hand-off. Depends on rbpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbpcd_ctrl
	import rbpcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire rbp_status_t status,
	output rbp_cmd_t         cmd
);

	rbp_state_t state_q;
	rbp_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_next   = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				// Fill and finish come back here once for every byte they touch.
				state_next = status.more ? ST_READ : ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_full) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/rbpcd_dp.sv @@
// Datapath for the report bit packer: report memory with per-byte valid bits,
// cursor, change flag, length register and the result register. Uses rbpcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbpcd_dp
	import rbpcd_pkg::*;
#(
	parameter int MAX_BYTES = RBP_MAX_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rbp_item_t   item,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	input  wire rbp_cmd_t    cmd,
	output rbp_status_t      status,
	output logic             result_valid,
	input  wire logic        result_stall,
	output rbp_result_t      result
);

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam logic [6:0] MaxLen = 7'(MAX_BYTES);

	// Item fields held for the duration of the item.
	logic [2:0]  action_q;
	logic [7:0]  byte_value_q;
	logic        bit_value_q;
	logic [7:0]  remaining_q;
	logic [5:0]  byte_index_q;

	logic [6:0]  len_q;
	logic [9:0]  cursor_q;
	logic        flag_q;
	logic [7:0]  rd_out_q;

	logic [7:0]  mem_q [MAX_BYTES];
	logic [MAX_BYTES-1:0] vld_q;
	logic [7:0]  rd_data_q;
	logic        rd_vld_q;

	logic        result_valid_q;
	rbp_result_t result_q;

	logic [6:0]  eff_len;
	logic [9:0]  limit;
	logic        in_lim;
	logic [9:0]  room;
	logic [2:0]  off;
	logic [9:0]  span;
	logic [9:0]  want;
	logic [9:0]  n_a;
	logic [9:0]  n_b;
	logic [3:0]  n;
	logic [7:0]  mask;
	logic [7:0]  old_byte;
	logic [7:0]  new_byte;
	logic        wr_action;
	logic        we;
	logic [9:0]  cursor_next;
	logic [7:0]  rem_next;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign eff_len = (len_q > MaxLen) ? MaxLen : len_q;
	assign limit   = {eff_len, 3'b000};
	assign in_lim  = cursor_q < limit;
	assign room    = in_lim ? (limit - cursor_q) : 10'd0;
	assign off     = cursor_q[2:0];
	assign span    = 10'd8 - {7'd0, off};
	assign old_byte = rd_vld_q ? rd_data_q : 8'd0;
	assign wr_addr = cursor_q[AW+2:3];
	assign rd_addr = (action_q == ACT_READ) ? byte_index_q[AW-1:0] : wr_addr;

	always_comb begin
		case (action_q)
			ACT_ADD_BYTE: want = (off == 3'd0) ? 10'd8 : 10'd0;
			ACT_ADD_BIT:  want = 10'd1;
			ACT_FILL:     want = {2'b00, remaining_q};
			ACT_FINISH:   want = room;
			default:      want = 10'd0;
		endcase
	end

	// Bits written in this step: no more than the rest of the current byte,
	// the bits still asked for and the room left before the limit.
	assign n_a  = (span < want) ? span : want;
	assign n_b  = (n_a < room) ? n_a : room;
	assign n    = n_b[3:0];
	assign mask = 8'((9'd1 << n) - 9'd1) << off;

	always_comb begin
		case (action_q)
			ACT_ADD_BYTE: new_byte = byte_value_q;
			ACT_ADD_BIT:  new_byte = bit_value_q ? (old_byte | mask) : (old_byte & ~mask);
			default:      new_byte = old_byte & ~mask;
		endcase
	end

	assign wr_action = (action_q == ACT_ADD_BYTE) || (action_q == ACT_ADD_BIT)
		|| (action_q == ACT_FILL) || (action_q == ACT_FINISH);
	assign we          = cmd.step && wr_action && (n != 4'd0);
	assign cursor_next = cursor_q + 10'(n);
	assign rem_next    = remaining_q - 8'(n);

	assign status.more = (n != 4'd0) && (cursor_next < limit)
		&& (((action_q == ACT_FILL) && (rem_next != 8'd0)) || (action_q == ACT_FINISH));
	assign status.out_full = result_valid_q && result_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q     <= item.action;
			byte_value_q <= item.byte_value;
			bit_value_q  <= item.bit_value;
			byte_index_q <= item.byte_index;
			remaining_q  <= item.bit_count;
		end else if (cmd.step) begin
			remaining_q <= rem_next;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
		if (we) begin
			mem_q[wr_addr] <= new_byte;
		end
		if (cmd.step) begin
			if (action_q == ACT_READ && {1'b0, byte_index_q} < MaxLen) begin
				rd_out_q <= old_byte;
			end else begin
				rd_out_q <= 8'd0;
			end
		end
		if (cmd.out_load) begin
			result_q.read_data    <= rd_out_q;
			result_q.changed      <= flag_q;
			result_q.bit_position <= cursor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= RBP_LEN_RESET;
			cursor_q       <= '0;
			flag_q         <= 1'b0;
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (cmd.step) begin
				if (action_q == ACT_CLEAR) begin
					// An entry without its valid bit reads as zero.
					vld_q    <= '0;
					cursor_q <= '0;
					flag_q   <= 1'b0;
				end else if (action_q == ACT_RESTART) begin
					cursor_q <= '0;
				end else if (we) begin
					vld_q[wr_addr] <= 1'b1;
					cursor_q       <= cursor_next;
					if (new_byte != old_byte) begin
						flag_q <= 1'b1;
					end
				end
			end
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ hdl/report_bit_packer_change_detect.sv @@
// Report bit packer with change detection: builds a report LSB first through a
// bit cursor and flags any change to a stored bit. Top level; uses rbpcd_pkg,
// rbpcd_ctrl and rbpcd_dp.
//
// Usage: items arrive on item/item_valid/item_stall and each one gives exactly
// one result on result/result_valid/result_stall; both sides hand over an item
// on a clock edge with valid high and stall low. The report length is written
// through cfg_we/cfg_wdata while no item is in flight.
// Each item passes through a memory read state and a step state before its result
// moves into the output register. Fill and finish repeat the memory read and the
// read-modify-write for every further report byte they touch; the single-port
// report memory sets this pace.
// Throughput: one item at a time; item_stall is high from acceptance until the
// result moves into the output register, which waits while the previous result
// is still stalled there, so the next item is taken once that register frees.
// When the receiver stalls, the result is held and a finished item waits.
// Reset clears the cursor, the changed flag and all byte valid bits (so the
// report reads as zero) and sets the length to eight bytes; no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module report_bit_packer_change_detect
	import rbpcd_pkg::*;
#(
	parameter int MAX_BYTES = RBP_MAX_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire rbp_item_t   item,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	output logic             result_valid,
	input  wire logic        result_stall,
	output rbp_result_t      result
);

	rbp_cmd_t    cmd;
	rbp_status_t status;

	rbpcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	rbpcd_dp #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Accepting an item closes the input until its result moves into the output register.
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input stayed open after an item was accepted");

	// A new result never overwrites one that the receiver is still stalling.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(result_valid && result_stall))
		else $error("result register overwritten while stalled");

	// A result only appears after the controller loaded one.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.out_load))
		else $error("result valid rose without a load");

endmodule

`default_nettype wire

@@ tb/report_bit_packer_change_detect_tb.sv @@
// Self-checking testbench for report_bit_packer_change_detect: directed and random
// items against a behavioural model of the report packer, with random idling on both
// channels. Depends on rbpcd_pkg and the block itself.
`timescale 1ns / 1ps

module report_bit_packer_change_detect_tb;
	import rbpcd_pkg::*;

	localparam logic [2:0] ACT_NOP = 3'd7;
	localparam int ITEM_TARGET = 1900;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	rbp_item_t   item;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic        result_valid;
	logic        result_stall;
	rbp_result_t result;

	// Behavioural copy of the report state.
	logic [7:0]  rpt_bytes [RBP_MAX_BYTES];
	int          rpt_cursor;
	logic        rpt_changed;
	int          rpt_len;

	rbp_result_t expected_q [$];
	int          fail_count;
	int          sent_items;
	int          burst_left;
	int          stall_mode;
	int          stall_cycles;

	report_bit_packer_change_detect u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int bit_limit();
		int n;
		n = rpt_len;
		if (n > RBP_MAX_BYTES) begin
			n = RBP_MAX_BYTES;
		end
		return n * 8;
	endfunction

	function automatic void store_bit(input logic b);
		int idx;
		int pos;
		if (rpt_cursor >= bit_limit()) begin
			return;
		end
		idx = rpt_cursor / 8;
		pos = rpt_cursor % 8;
		if (rpt_bytes[idx][pos] != b) begin
			rpt_changed = 1'b1;
			rpt_bytes[idx][pos] = b;
		end
		rpt_cursor++;
	endfunction

	function automatic void store_byte(input logic [7:0] value);
		int idx;
		if ((rpt_cursor % 8) != 0 || rpt_cursor >= bit_limit()) begin
			return;
		end
		idx = rpt_cursor / 8;
		if (rpt_bytes[idx] != value) begin
			rpt_changed = 1'b1;
			rpt_bytes[idx] = value;
		end
		rpt_cursor += 8;
	endfunction

	function automatic void clear_report();
		foreach (rpt_bytes[i]) begin
			rpt_bytes[i] = 8'h00;
		end
		rpt_cursor = 0;
		rpt_changed = 1'b0;
	endfunction

	// Applies one item to the model and returns the result it should produce.
	function automatic rbp_result_t pack_and_report(input rbp_item_t it);
		rbp_result_t r;
		r.read_data = 8'h00;
		case (it.action)
			ACT_CLEAR: begin
				clear_report();
			end
			ACT_RESTART: begin
				rpt_cursor = 0;
			end
			ACT_ADD_BYTE: begin
				store_byte(it.byte_value);
			end
			ACT_ADD_BIT: begin
				store_bit(it.bit_value);
			end
			ACT_FILL: begin
				for (int i = 0; i < int'(it.bit_count); i++) begin
					store_bit(1'b0);
				end
			end
			ACT_FINISH: begin
				while (rpt_cursor < bit_limit()) begin
					store_bit(1'b0);
				end
			end
			ACT_READ: begin
				r.read_data = rpt_bytes[it.byte_index];
			end
			default: begin
			end
		endcase
		r.changed = rpt_changed;
		r.bit_position = rpt_cursor[9:0];
		return r;
	endfunction

	// Unused fields carry random values so that every bit toggles.
	function automatic rbp_item_t rand_item(input logic [2:0] act);
		rbp_item_t it;
		it.action     = act;
		it.byte_value = 8'($urandom);
		it.bit_value  = 1'($urandom);
		it.bit_count  = 8'($urandom);
		it.byte_index = 6'($urandom);
		return it;
	endfunction

	task automatic send_item(input rbp_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item       <= it;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (item_stall);
		expected_q.push_back(pack_and_report(it));
		sent_items++;
	endtask

	task automatic send_action(input logic [2:0] act, input int arg = 0);
		rbp_item_t it;
		it = rand_item(act);
		case (act)
			ACT_ADD_BYTE: it.byte_value = 8'(arg);
			ACT_ADD_BIT:  it.bit_value  = 1'(arg);
			ACT_FILL:     it.bit_count  = 8'(arg);
			ACT_READ:     it.byte_index = 6'(arg);
			default: begin
			end
		endcase
		send_item(it);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// The length may only change while nothing is in flight.
	task automatic set_report_len(input int len);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= 7'(len);
		@(negedge clk);
		cfg_we    <= 1'b0;
		rpt_len = len;
	endtask

	task automatic test_basic_actions();
		send_action(ACT_READ, 0);
		send_action(ACT_ADD_BYTE, 8'hFF);
		send_action(ACT_ADD_BYTE, 8'h00);
		send_action(ACT_ADD_BIT, 1);
		send_action(ACT_ADD_BYTE, 8'hA5);
		send_action(ACT_ADD_BIT, 0);
		send_action(ACT_FILL, 0);
		send_action(ACT_FILL, 5);
		send_action(ACT_ADD_BYTE, 8'h3C);
		send_action(ACT_FILL, 255);
		send_action(ACT_ADD_BYTE, 8'h11);
		send_action(ACT_ADD_BIT, 1);
		send_action(ACT_FINISH);
		send_action(ACT_READ, 0);
		send_action(ACT_READ, 63);
		send_action(ACT_NOP);
		send_action(ACT_RESTART);
		send_action(ACT_ADD_BYTE, 8'hFF);
		send_action(ACT_READ, 0);
		send_action(ACT_CLEAR);
		send_action(ACT_ADD_BYTE, 8'h00);
		send_action(ACT_FINISH);
		send_action(ACT_READ, 7);
	endtask

	task automatic test_length_edges();
		// An empty report ignores every write.
		set_report_len(0);
		send_action(ACT_CLEAR);
		send_action(ACT_ADD_BYTE, 8'h5A);
		send_action(ACT_ADD_BIT, 1);
		send_action(ACT_FILL, 9);
		send_action(ACT_FINISH);
		// Above the maximum the report is clamped to the full store.
		set_report_len(127);
		send_action(ACT_ADD_BIT, 1);
		send_action(ACT_FINISH);
		send_action(ACT_READ, 63);
		set_report_len(64);
		send_action(ACT_RESTART);
		send_action(ACT_FILL, 200);
		send_action(ACT_ADD_BYTE, 8'h80);
		// Shortening the report below the cursor freezes writing until restart.
		set_report_len(8);
		send_action(ACT_ADD_BIT, 1);
		send_action(ACT_ADD_BYTE, 8'h01);
		send_action(ACT_FINISH);
		send_action(ACT_RESTART);
		send_action(ACT_ADD_BIT, 1);
		set_report_len(1);
		send_action(ACT_FILL, 3);
		send_action(ACT_ADD_BYTE, 8'h7E);
		send_action(ACT_FINISH);
		send_action(ACT_READ, 0);
	endtask

	// One well-formed report: start, a run of mostly writes, usually a finish, then reads.
	task automatic random_report();
		int steps;
		int pick;
		int len_bytes;
		len_bytes = (rpt_len > RBP_MAX_BYTES) ? RBP_MAX_BYTES : rpt_len;
		send_action(($urandom_range(0, 2) == 0) ? ACT_RESTART : ACT_CLEAR);
		steps = $urandom_range(1, 14);
		repeat (steps) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_action(ACT_ADD_BYTE, $urandom_range(0, 255));
			end else if (pick < 72) begin
				send_action(ACT_ADD_BIT, $urandom_range(0, 1));
			end else if (pick < 86) begin
				send_action(ACT_FILL, $urandom_range(0, 12));
			end else if (pick < 89) begin
				send_action(ACT_FILL, $urandom_range(0, 255));
			end else if (pick < 94) begin
				send_action(ACT_READ, $urandom_range(0, 63));
			end else if (pick < 97) begin
				send_action(ACT_NOP);
			end else begin
				send_action(ACT_RESTART);
			end
		end
		if ($urandom_range(0, 9) < 7) begin
			send_action(ACT_FINISH);
		end
		repeat ($urandom_range(1, 4)) begin
			if (len_bytes > 0 && $urandom_range(0, 4) != 0) begin
				send_action(ACT_READ, $urandom_range(0, len_bytes - 1));
			end else begin
				send_action(ACT_READ, $urandom_range(0, 63));
			end
		end
	endtask

	task automatic test_random_reports();
		int lengths [12];
		int target;
		lengths = '{8, 1, 64, 2, 0, 127, 5, 16, 65, 0, 0, 0};
		for (int k = 9; k < 12; k++) begin
			lengths[k] = $urandom_range(1, 64);
		end
		foreach (lengths[k]) begin
			set_report_len(lengths[k]);
			target = sent_items + ITEM_TARGET / 12;
			while (sent_items < target) begin
				random_report();
			end
		end
	endtask

	// Receiver stall: the pattern changes every so often, including quiet stretches.
	always @(negedge clk) begin
		if (stall_cycles == 0) begin
			stall_mode   <= $urandom_range(0, 3);
			stall_cycles <= $urandom_range(20, 150);
		end else begin
			stall_cycles <= stall_cycles - 1;
		end
		case (stall_mode)
			0:       result_stall <= 1'b0;
			1:       result_stall <= ($urandom_range(0, 3) == 0);
			2:       result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ((stall_cycles % 16) < 6);
		endcase
	end

	always @(posedge clk) begin
		rbp_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: %p", result);
				fail_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (result.read_data !== exp_r.read_data) begin
					$error("read_data: expected %0h, got %0h", exp_r.read_data,
						result.read_data);
					fail_count++;
				end
				if (result.changed !== exp_r.changed) begin
					$error("changed: expected %0b, got %0b", exp_r.changed, result.changed);
					fail_count++;
				end
				if (result.bit_position !== exp_r.bit_position) begin
					$error("bit_position: expected %0d, got %0d", exp_r.bit_position,
						result.bit_position);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("** report_bit_packer_change_detect: FAILED **");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		result_stall = 1'b0;
		stall_mode   = 0;
		stall_cycles = 0;
		fail_count   = 0;
		sent_items   = 0;
		burst_left   = 0;
		rpt_len      = int'(RBP_LEN_RESET);
		clear_report();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_actions();
		test_length_edges();
		test_random_reports();

		wait_idle();
		// Anything stray left after the last item shows up here.
		repeat (150) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("** report_bit_packer_change_detect: PASSED **");
		end else begin
			$display("** report_bit_packer_change_detect: FAILED **");
		end
		$finish;
	end

endmodule
